/* hdl/pag_pkg.sv */
`timescale 1ns / 1ps
package pag_pkg;

  localparam int NumSlotsDef = 16;

  typedef enum logic [1:0] {
    ActAdmit   = 2'd0,
    ActObserve = 2'd1,
    ActTick    = 2'd2,
    ActRelease = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    DecMore   = 2'd0,
    DecOk     = 2'd1,
    DecReject = 2'd2
  } decision_e;

  typedef enum logic [2:0] {
    WhyNone   = 3'd0,
    WhyFamily = 3'd1,
    WhyGroup  = 3'd2,
    WhyTable  = 3'd3,
    WhySlot   = 3'd4,
    WhyTime   = 3'd5,
    WhySize   = 3'd6,
    WhyHeader = 3'd7
  } reason_e;

  localparam logic [2:0] RegMaxV4    = 3'd0;
  localparam logic [2:0] RegMaxV6    = 3'd1;
  localparam logic [2:0] RegDeadline = 3'd2;
  localparam logic [2:0] RegGrace    = 3'd3;
  localparam logic [2:0] RegMinRate  = 3'd4;
  localparam logic [2:0] RegMaxHello = 3'd5;

  localparam logic [7:0]  MarkerHello = 8'hE3;
  localparam logic [7:0]  OpHello     = 8'h01;
  localparam logic [7:0]  FamV4       = 8'd4;
  localparam logic [7:0]  FamV6       = 8'd6;
  localparam logic [31:0] HdrLen      = 32'd6;
  localparam logic [31:0] MinPlen     = 32'd2;
  localparam logic [32:0] FrameExtra  = 33'd5;
  localparam logic [9:0]  MsPerSec    = 10'd1000;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  family;
    logic [63:0] group_prefix;
    logic [7:0]  slot_sel;
    logic [63:0] now_ms;
    logic [31:0] buffered_len;
    logic [7:0]  marker_byte;
    logic [31:0] packet_length;
    logic [7:0]  opcode_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]  decision;
    logic [2:0]  reason;
    logic [7:0]  slot_out;
    logic [15:0] frame_len;
  } rsp_t;

endpackage

/* hdl/pag_if.sv */
`timescale 1ns / 1ps
interface pag_req_if;
  import pag_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pag_rsp_if;
  import pag_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/preauth_admission_gate.sv */
`timescale 1ns / 1ps
// admit scans the slots in turn, then decides; observe and tick read, multiply, then compare;
// others decide on acceptance. One item at a time: the next item is taken the cycle after the
//   result leaves
// time checks share one 32x32 multiplier
// reset: asynchronous active low; registers to defaults, all slots free, payload memory unreset
module preauth_admission_gate #(
  parameter int NUM_SLOTS = pag_pkg::NumSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  pag_req_if.sink     req,
  pag_rsp_if.source   rsp
);
  import pag_pkg::*;

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam logic [CW-1:0] LastSlot = CW'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    StIdle, StScan, StAdmit, StRead, StMul, StCmp, StDone
  } state_e;

  // configuration
  logic [7:0]  max_v4_q, max_v6_q;
  logic [31:0] deadline_q, grace_q, min_rate_q;
  logic [15:0] max_hello_q;

  // slot table: valid and family bits in flops, payload in memory
  logic [NUM_SLOTS-1:0] busy_q, v6_q;
  logic [63:0] grp_mem [NUM_SLOTS];
  logic [63:0] time_mem [NUM_SLOTS];
  logic [31:0] peak_mem [NUM_SLOTS];

  state_e      state_q;
  req_t        req_q;
  logic [CW-1:0] idx_q;
  logic [7:0]  same_q;
  logic        same_sat_q;
  logic        free_found_q;
  logic [SW-1:0] free_q;
  logic [63:0] rd_grp_q, rd_time_q;
  logic [31:0] rd_peak_q;
  logic [31:0] el_q;
  logic        el_big_q;
  logic [63:0] lhs_q, rhs_q;
  logic        mul_stage_q;
  rsp_t        rsp_q;
  logic        rsp_valid_q;

  logic [SW-1:0] scan_idx, sel_idx;
  assign scan_idx = idx_q[SW-1:0];
  assign sel_idx  = req_q.slot_sel[SW-1:0];

  assign req.ready = (state_q == StIdle) && !rsp_valid_q;
  assign rsp.valid = rsp_valid_q;
  assign rsp.data  = rsp_q;

  // scan compare for the current slot
  logic is_v6, match;
  assign is_v6 = (req_q.family == FamV6);
  always_comb begin
    match = (v6_q[scan_idx] == is_v6) &&
            (is_v6 ? (rd_grp_q == req_q.group_prefix)
                   : (rd_grp_q[63:32] == req_q.group_prefix[63:32]));
  end

  // elapsed time, clamped at zero when the clock is behind admission
  logic [63:0] el_full;
  logic [31:0] peak_new;
  assign el_full = (req_q.now_ms >= rd_time_q) ? (req_q.now_ms - rd_time_q) : 64'd0;
  assign peak_new = (req_q.action == ActObserve && req_q.buffered_len > rd_peak_q)
                  ? req_q.buffered_len : rd_peak_q;

  // shared multiplier: peak*1000 then min_rate*elapsed
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_a = mul_stage_q ? min_rate_q : peak_new;
  assign mul_b = mul_stage_q ? el_q : {22'd0, MsPerSec};
  assign mul_p = mul_a * mul_b;

  logic time_fail;
  assign time_fail = el_big_q || (el_q >= deadline_q) ||
                     ((el_q > grace_q) && (lhs_q < rhs_q));

  logic [32:0] frame;
  assign frame = {1'b0, req_q.packet_length} + FrameExtra;

  logic [7:0] limit;
  assign limit = is_v6 ? max_v6_q : max_v4_q;

  function automatic rsp_t mk(decision_e d, reason_e r, logic [7:0] s, logic [15:0] f);
    rsp_t o;
    o.decision = d;
    o.reason = r;
    o.slot_out = s;
    o.frame_len = f;
    return o;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_v4_q <= 8'd4;
      max_v6_q <= 8'd4;
      deadline_q <= 32'd10000;
      grace_q <= 32'd2000;
      min_rate_q <= 32'd64;
      max_hello_q <= 16'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMaxV4:    max_v4_q <= cfg_data_i[7:0];
        RegMaxV6:    max_v6_q <= cfg_data_i[7:0];
        RegDeadline: deadline_q <= cfg_data_i;
        RegGrace:    grace_q <= cfg_data_i;
        RegMinRate:  min_rate_q <= cfg_data_i;
        RegMaxHello: max_hello_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // payload memory; while idle the time and peak reads follow the incoming item, the group read slot 0
  always_ff @(posedge clk_i) begin
    if (state_q == StAdmit && free_found_q && !(same_sat_q || same_q >= limit)) begin
      grp_mem[free_q] <= req_q.group_prefix;
      time_mem[free_q] <= req_q.now_ms;
      peak_mem[free_q] <= 32'd0;
    end else if (state_q == StMul && mul_stage_q && req_q.action == ActObserve) begin
      peak_mem[sel_idx] <= peak_new;
    end
    rd_grp_q <= grp_mem[(state_q == StIdle) ? '0 : SW'(idx_q + CW'(1))];
    rd_time_q <= time_mem[(state_q == StIdle) ? req.data.slot_sel[SW-1:0] : sel_idx];
    rd_peak_q <= peak_mem[(state_q == StIdle) ? req.data.slot_sel[SW-1:0] : sel_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q <= '0;
      v6_q <= '0;
      rsp_valid_q <= 1'b0;
      idx_q <= '0;
      same_q <= '0;
      same_sat_q <= 1'b0;
      free_found_q <= 1'b0;
      free_q <= '0;
      mul_stage_q <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (req.valid && req.ready) begin
            req_q <= req.data;
            idx_q <= '0;
            same_q <= '0;
            same_sat_q <= 1'b0;
            free_found_q <= 1'b0;
            mul_stage_q <= 1'b0;
            if (req.data.action == ActAdmit) begin
              if (req.data.family != FamV4 && req.data.family != FamV6) begin
                rsp_q <= mk(DecReject, WhyFamily, 8'd0, 16'd0);
                state_q <= StDone;
              end else begin
                state_q <= StScan;
              end
            end else if ({24'd0, req.data.slot_sel} >= NUM_SLOTS ||
                         !busy_q[req.data.slot_sel[SW-1:0]]) begin
              rsp_q <= mk(DecReject, WhySlot, 8'd0, 16'd0);
              state_q <= StDone;
            end else if (req.data.action == ActRelease) begin
              busy_q[req.data.slot_sel[SW-1:0]] <= 1'b0;
              v6_q[req.data.slot_sel[SW-1:0]] <= 1'b0;
              rsp_q <= mk(DecOk, WhyNone, 8'd0, 16'd0);
              state_q <= StDone;
            end else begin
              state_q <= StRead;
            end
          end
        end
        StScan: begin
          // one slot per cycle: count matching groups, note first free slot
          if (!busy_q[scan_idx]) begin
            if (!free_found_q) begin
              free_found_q <= 1'b1;
              free_q <= scan_idx;
            end
          end else if (match) begin
            if (same_q == 8'hFF) same_sat_q <= 1'b1;
            same_q <= same_q + 8'd1;
          end
          if (idx_q == LastSlot) state_q <= StAdmit;
          idx_q <= idx_q + CW'(1);
        end
        StAdmit: begin
          if (same_sat_q || same_q >= limit) begin
            rsp_q <= mk(DecReject, WhyGroup, 8'd0, 16'd0);
          end else if (!free_found_q) begin
            rsp_q <= mk(DecReject, WhyTable, 8'd0, 16'd0);
          end else begin
            busy_q[free_q] <= 1'b1;
            v6_q[free_q] <= is_v6;
            rsp_q <= mk(DecOk, WhyNone, 8'(free_q), 16'd0);
          end
          state_q <= StDone;
        end
        StRead: begin
          // memory read data is now registered
          el_q <= el_full[31:0];
          el_big_q <= |el_full[63:32];
          state_q <= StMul;
        end
        StMul: begin
          if (!mul_stage_q) begin
            lhs_q <= mul_p;
            mul_stage_q <= 1'b1;
          end else begin
            rhs_q <= mul_p;
            state_q <= StCmp;
          end
        end
        StCmp: begin
          priority if (time_fail) begin
            rsp_q <= mk(DecReject, WhyTime, 8'd0, 16'd0);
          end else if (req_q.action == ActTick) begin
            rsp_q <= mk(DecMore, WhyNone, 8'd0, 16'd0);
          end else if (req_q.buffered_len > {16'd0, max_hello_q}) begin
            rsp_q <= mk(DecReject, WhySize, 8'd0, 16'd0);
          end else if (req_q.buffered_len < HdrLen) begin
            rsp_q <= mk(DecMore, WhyNone, 8'd0, 16'd0);
          end else if (req_q.marker_byte != MarkerHello || req_q.opcode_byte != OpHello ||
                       req_q.packet_length < MinPlen || frame > {17'd0, max_hello_q}) begin
            rsp_q <= mk(DecReject, WhyHeader, 8'd0, 16'd0);
          end else if ({1'b0, req_q.buffered_len} < frame) begin
            rsp_q <= mk(DecMore, WhyNone, 8'd0, 16'd0);
          end else begin
            rsp_q <= mk(DecOk, WhyNone, 8'd0, frame[15:0]);
          end
          state_q <= StDone;
        end
        StDone: begin
          rsp_valid_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // a result is raised only out of the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == StDone)
    else $error("result without done state");
  // family bit only set on busy slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v6_q & ~busy_q) == '0)
    else $error("v6 flag on free slot");
  // a granted slot was free before the grant
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StAdmit && free_found_q) |-> !busy_q[free_q])
    else $error("granted slot busy");
  // no new item while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> !req.ready)
    else $error("ready with pending result");
endmodule
